// File: design/loop_branch_profiler_top_defines.svh
// Assertion macros for the loop branch profiler.
// Used by loop_branch_profiler_top; expects aclk and aresetn in scope.
`ifndef LOOP_BRANCH_PROFILER_TOP_DEFINES_SVH
`define LOOP_BRANCH_PROFILER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lbp_pkg.sv
// Shared constants, types and helpers of the loop branch profiler.
// No dependencies.
package lbp_pkg;

    localparam int LOOP_ENTRIES = 64;
    localparam int ADDR_BITS    = 48;
    localparam int CNT_BITS     = 32;
    localparam int IDX_W        = (LOOP_ENTRIES > 1) ? $clog2(LOOP_ENTRIES) : 1;
    localparam int SCAN_W       = $clog2(LOOP_ENTRIES + 1);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]     idx_t;

    // One table record, less the head address, which has a memory of its own.
    typedef struct packed {
        addr_t tail;
        cnt_t  iters;
        cnt_t  invokes;
        cnt_t  prior;
        cnt_t  changes;
    } loop_rec_t;

    // Outcome of a head search.
    typedef struct packed {
        logic done;
        logic hit;
        logic avail;
        idx_t idx;
    } search_res_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// File: design/loop_branch_profiler_top.sv
// Loop branch profiler top level: sequencer, valid bits, head and record
// memories, output register. Depends on lbp_pkg, lbp_ram, lbp_search and the defines header.

// For a branch event that looks up the table, the head memory is walked one
// entry per cycle through its single read port; then, unless the table is
// full, the record is read and written back once. A hit ends the walk early.
// A table read skips the walk and a taken forward branch touches no entry.
// One transaction is in work at a time; the result sits in an output
// register so the next transaction can be taken while it waits. No clearing
// pass after reset.
module loop_branch_profiler_top
    import lbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  addr_t       s_branch_target,
    input  addr_t       s_fall_through_addr,
    input  logic        s_taken,
    input  logic [5:0]  s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_entry_valid,
    output addr_t       m_head_addr,
    output addr_t       m_tail_addr,
    output cnt_t        m_iteration_total,
    output cnt_t        m_invocation_total,
    output cnt_t        m_change_total,
    output logic        m_overflowed
);
    `include "loop_branch_profiler_top_defines.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FETCH,
        ST_APPLY
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_ITER,
        OP_EXIT,
        OP_DROP
    } op_kind_t;

    state_t   state_reg, state_next;
    op_kind_t kind_reg, kind_next;
    addr_t    target_reg, target_next;
    addr_t    ft_reg, ft_next;
    idx_t     ent_reg, ent_next;
    logic     alloc_reg, alloc_next;
    logic     rd_ok_reg, rd_ok_next;
    logic [LOOP_ENTRIES-1:0] used_reg, used_next;
    cnt_t     running_reg, running_next;
    logic     drop_reg, drop_next;

    logic     m_valid_reg, m_valid_next;
    logic     m_entry_valid_reg, m_entry_valid_next;
    addr_t    m_head_addr_reg, m_head_addr_next;
    addr_t    m_tail_addr_reg, m_tail_addr_next;
    cnt_t     m_iter_reg, m_iter_next;
    cnt_t     m_invoke_reg, m_invoke_next;
    cnt_t     m_change_reg, m_change_next;
    logic     m_ovf_reg, m_ovf_next;

    logic        out_free;
    logic        srch_start;
    search_res_t srch_res;
    idx_t        srch_addr;
    idx_t        head_raddr;
    addr_t       head_q;
    logic        head_we;
    loop_rec_t   rec_q;
    loop_rec_t   old_rec;
    loop_rec_t   new_rec;
    logic        rec_we;

    lbp_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (LOOP_ENTRIES)
    ) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (ent_reg),
        .wdata (target_reg),
        .raddr (head_raddr),
        .rdata (head_q)
    );

    lbp_ram #(
        .WIDTH ($bits(loop_rec_t)),
        .DEPTH (LOOP_ENTRIES)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (ent_reg),
        .wdata (new_rec),
        .raddr (ent_reg),
        .rdata (rec_q)
    );

    lbp_search u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (srch_start),
        .key     (target_reg),
        .used    (used_reg),
        .head_q  (head_q),
        .rd_addr (srch_addr),
        .res     (srch_res)
    );

    assign head_raddr = (state_reg == ST_SEARCH) ? srch_addr : ent_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    // a freshly allocated entry starts from zero
    assign old_rec    = alloc_reg ? '0 : rec_q;

    always_comb begin
        state_next         = state_reg;
        kind_next          = kind_reg;
        target_next        = target_reg;
        ft_next            = ft_reg;
        ent_next           = ent_reg;
        alloc_next         = alloc_reg;
        rd_ok_next         = rd_ok_reg;
        used_next          = used_reg;
        running_next       = running_reg;
        drop_next          = drop_reg;
        m_valid_next       = m_valid_reg;
        m_entry_valid_next = m_entry_valid_reg;
        m_head_addr_next   = m_head_addr_reg;
        m_tail_addr_next   = m_tail_addr_reg;
        m_iter_next        = m_iter_reg;
        m_invoke_next      = m_invoke_reg;
        m_change_next      = m_change_reg;
        m_ovf_next         = m_ovf_reg;
        srch_start         = 1'b0;
        head_we            = 1'b0;
        rec_we             = 1'b0;
        new_rec            = old_rec;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    target_next = s_branch_target;
                    ft_next     = s_fall_through_addr;
                    alloc_next  = 1'b0;
                    if (s_command) begin
                        kind_next  = OP_READ;
                        ent_next   = IDX_W'(s_read_index);
                        rd_ok_next = (int'(s_read_index) < LOOP_ENTRIES) &&
                                     used_reg[IDX_W'(s_read_index)];
                        state_next = ST_FETCH;
                    end else if (s_taken && !(s_branch_target < s_fall_through_addr)) begin
                        kind_next  = OP_NONE;
                        state_next = ST_APPLY;
                    end else begin
                        kind_next  = s_taken ? OP_ITER : OP_EXIT;
                        srch_start = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (srch_res.done) begin
                    ent_next = srch_res.idx;
                    if (srch_res.hit) begin
                        state_next = ST_FETCH;
                    end else if (srch_res.avail) begin
                        alloc_next = 1'b1;
                        state_next = ST_FETCH;
                    end else begin
                        // table full: drop the event
                        kind_next  = OP_DROP;
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_entry_valid_next = 1'b0;
                    m_head_addr_next   = '0;
                    m_tail_addr_next   = '0;
                    m_iter_next        = '0;
                    m_invoke_next      = '0;
                    m_change_next      = '0;
                    m_ovf_next         = drop_reg;
                    case (kind_reg)
                        OP_READ: begin
                            if (rd_ok_reg) begin
                                m_entry_valid_next = (rec_q.tail != '0);
                                m_head_addr_next   = head_q;
                                m_tail_addr_next   = rec_q.tail;
                                m_iter_next        = rec_q.iters;
                                m_invoke_next      = rec_q.invokes;
                                m_change_next      = rec_q.changes;
                            end
                        end
                        OP_ITER: begin
                            if (ft_reg > old_rec.tail) begin
                                new_rec.tail  = ft_reg;
                                new_rec.iters = cnt_t'(1);
                            end else if (ft_reg == old_rec.tail) begin
                                new_rec.iters = sat_inc(old_rec.iters);
                            end
                            rec_we             = 1'b1;
                            head_we            = alloc_reg;
                            used_next[ent_reg] = 1'b1;
                            running_next       = sat_inc(running_reg);
                        end
                        OP_EXIT: begin
                            new_rec.invokes = sat_inc(old_rec.invokes);
                            if (running_reg != old_rec.prior) begin
                                new_rec.changes = sat_inc(old_rec.changes);
                            end
                            new_rec.prior      = running_reg;
                            rec_we             = 1'b1;
                            head_we            = alloc_reg;
                            used_next[ent_reg] = 1'b1;
                            running_next       = '0;
                        end
                        OP_DROP: begin
                            drop_next  = 1'b1;
                            m_ovf_next = 1'b1;
                        end
                        default: ;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            running_reg <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            running_reg <= running_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg          <= kind_next;
        target_reg        <= target_next;
        ft_reg            <= ft_next;
        ent_reg           <= ent_next;
        alloc_reg         <= alloc_next;
        rd_ok_reg         <= rd_ok_next;
        m_entry_valid_reg <= m_entry_valid_next;
        m_head_addr_reg   <= m_head_addr_next;
        m_tail_addr_reg   <= m_tail_addr_next;
        m_iter_reg        <= m_iter_next;
        m_invoke_reg      <= m_invoke_next;
        m_change_reg      <= m_change_next;
        m_ovf_reg         <= m_ovf_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_entry_valid      = m_entry_valid_reg;
    assign m_head_addr        = m_head_addr_reg;
    assign m_tail_addr        = m_tail_addr_reg;
    assign m_iteration_total  = m_iter_reg;
    assign m_invocation_total = m_invoke_reg;
    assign m_change_total     = m_change_reg;
    assign m_overflowed       = m_ovf_reg;

    `LBP_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "accepted while busy")
    `LBP_ASSERT_NEXT(a_drop_sticky, drop_reg, drop_reg, "overflow flag cleared")
    `LBP_ASSERT_NOW(a_search_in_state, srch_res.done, state_reg == ST_SEARCH, "stray search done")
    `LBP_ASSERT_NOW(a_write_owned, rec_we, used_reg[ent_reg] || alloc_reg, "write to free entry")

endmodule

// File: design/lbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/lbp_search.sv
// Sequential head search: walks the head memory one entry a cycle, compares
// each entry in the cycle after its read, and tracks the first free entry. Depends on lbp_pkg.
module lbp_search
    import lbp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  addr_t                   key,
    input  logic [LOOP_ENTRIES-1:0] used,
    input  addr_t                   head_q,
    output idx_t                    rd_addr,
    output search_res_t             res
);

    logic              busy_reg, busy_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic              chk_vld_reg, chk_vld_next;
    idx_t              chk_idx_reg, chk_idx_next;
    logic              free_vld_reg, free_vld_next;
    idx_t              free_idx_reg, free_idx_next;
    idx_t              scan_idx;

    assign scan_idx = scan_reg[IDX_W-1:0];
    assign rd_addr  = scan_idx;

    always_comb begin
        busy_next     = busy_reg;
        scan_next     = scan_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        res           = '0;

        if (start) begin
            busy_next     = 1'b1;
            scan_next     = '0;
            free_vld_next = 1'b0;
        end else if (busy_reg) begin
            // issue stage
            if (scan_reg < SCAN_W'(LOOP_ENTRIES)) begin
                chk_vld_next = 1'b1;
                chk_idx_next = scan_idx;
                scan_next    = scan_reg + 1'b1;
                if (!used[scan_idx] && !free_vld_reg) begin
                    free_vld_next = 1'b1;
                    free_idx_next = scan_idx;
                end
            end
            // compare stage
            if (chk_vld_reg && used[chk_idx_reg] && head_q == key) begin
                res.done     = 1'b1;
                res.hit      = 1'b1;
                res.idx      = chk_idx_reg;
                busy_next    = 1'b0;
                chk_vld_next = 1'b0;
            end else if (chk_vld_reg && chk_idx_reg == IDX_W'(LOOP_ENTRIES - 1)) begin
                res.done     = 1'b1;
                res.avail    = free_vld_reg;
                res.idx      = free_idx_reg;
                busy_next    = 1'b0;
                chk_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            chk_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            chk_vld_reg  <= chk_vld_next;
            free_vld_reg <= free_vld_next;
        end
        scan_reg     <= scan_next;
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
    end

endmodule
